[hdl/gdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdr_pkg: shared types and constants of the duplicate replacer
// Default sizes and the control and status bundles between the controller
// and the row of compare cells.
// ----------------------------------------------------------------------------
package gdr_pkg;

	// Default number of stored genes and gene width.
	localparam int DEF_MAX_GENES = 64;
	localparam int DEF_GENE_BITS = 32;

	// Commands from the controller, broadcast to every cell.
	typedef struct packed {
		logic start;   // launch a compare wave into the first cell
		logic shift;   // shift the stored set one cell down, new value enters cell 0
		logic clear;   // drop every stored value (end of genome)
	} gdr_cmd_t;

	// Status from the far end of the cell row.
	typedef struct packed {
		logic done;    // compare wave has left the last cell
		logic dup;     // some stored value matched the probe
	} gdr_stat_t;

endpackage

[hdl/genome_duplicate_replacer_core.sv]
`timescale 1ns / 1ps
// The compare wave walks the row of MAX_GENES cells one cell per cycle; the next gene
// is taken only after the wave is through and its result has entered the output register.
// A finished result waits in the output register while the next gene scans.
// Reset (arst_n low) clears the stored set, the fill count and all handshakes.
// ----------------------------------------------------------------------------
// genome_duplicate_replacer_core: duplicate gene replacement over a genome
// Emits each gene, or its replacement word when the gene equals one of the first
// MAX_GENES values emitted in the same genome; the set is dropped after the last gene.
// ----------------------------------------------------------------------------
module genome_duplicate_replacer_core #(
	parameter int MAX_GENES = gdr_pkg::DEF_MAX_GENES,
	parameter int GENE_BITS = gdr_pkg::DEF_GENE_BITS,
	localparam int S_W = ((2 * GENE_BITS + 7) / 8) * 8,
	localparam int M_W = ((GENE_BITS + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [S_W-1:0] s_tdata,   // gene, replacement, zero fill
	input  logic           s_tlast,   // last
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [M_W-1:0] m_tdata,   // gene_out, zero fill
	output logic [1:0]     m_tuser,   // replaced, overflow
	output logic           m_tlast    // last_out
);
	import gdr_pkg::*;

	gdr_cmd_t             cmd;
	gdr_stat_t            stat;
	logic [GENE_BITS-1:0] probe;
	logic [GENE_BITS-1:0] emit;
	logic [GENE_BITS-1:0] out_gene;
	logic                 out_replaced;
	logic                 out_overflow;

	logic [MAX_GENES:0]   tok;
	logic [MAX_GENES:0]   mat;
	logic [MAX_GENES:0]   vld;
	logic [GENE_BITS-1:0] val [MAX_GENES+1];

	// Controller.
	gdr_ctrl #(
		.MAX_GENES (MAX_GENES),
		.GENE_BITS (GENE_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_gene      (s_tdata[GENE_BITS-1:0]),
		.in_rep       (s_tdata[2*GENE_BITS-1:GENE_BITS]),
		.in_last      (s_tlast),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_gene     (out_gene),
		.out_replaced (out_replaced),
		.out_last     (m_tlast),
		.out_overflow (out_overflow),
		.cmd          (cmd),
		.stat         (stat),
		.probe        (probe),
		.emit         (emit)
	);

	// Head of the row: the wave starts clean and the new value enters here.
	assign tok[0] = cmd.start;
	assign mat[0] = 1'b0;
	assign val[0] = emit;
	assign vld[0] = 1'b1;

	// Row of storage and compare cells.
	for (genvar i = 0; i < MAX_GENES; i++) begin : g_cell
		gdr_cell #(
			.GENE_BITS (GENE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.probe   (probe),
			.tok_in  (tok[i]),
			.mat_in  (mat[i]),
			.val_in  (val[i]),
			.vld_in  (vld[i]),
			.tok_out (tok[i+1]),
			.mat_out (mat[i+1]),
			.val_out (val[i+1]),
			.vld_out (vld[i+1])
		);
	end

	// Tail of the row reports the finished wave and the match flag.
	assign stat.done = tok[MAX_GENES];
	assign stat.dup  = mat[MAX_GENES];

	// Output packing.
	assign m_tdata = M_W'(out_gene);
	assign m_tuser = {out_overflow, out_replaced};

endmodule

[hdl/gdr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdr_cell: one storage and compare cell
// Holds one emitted gene with its valid bit. A compare wave passes through
// one cell per cycle and picks up a match flag; on a store the held value
// moves on to the next cell.
// ----------------------------------------------------------------------------
module gdr_cell #(
	parameter int GENE_BITS = gdr_pkg::DEF_GENE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gdr_pkg::gdr_cmd_t    cmd,
	input  logic [GENE_BITS-1:0] probe,
	input  logic                 tok_in,
	input  logic                 mat_in,
	input  logic [GENE_BITS-1:0] val_in,
	input  logic                 vld_in,
	output logic                 tok_out,
	output logic                 mat_out,
	output logic [GENE_BITS-1:0] val_out,
	output logic                 vld_out
);
	import gdr_pkg::*;

	logic                 tok_q;
	logic                 mat_q;
	logic [GENE_BITS-1:0] value_q;
	logic                 valid_q;
	logic                 hit;

	// Local compare against the probe gene.
	assign hit = valid_q && (value_q == probe);

	// Wave token and match flag, handed on every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		mat_q <= mat_in | hit;
	end

	// Stored value shifts in from the neighbor on a store.
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			value_q <= val_in;
		end
	end

	// Valid bit; the end-of-genome clear wins over a store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= vld_in;
		end
	end

	assign tok_out = tok_q;
	assign mat_out = mat_q;
	assign val_out = value_q;
	assign vld_out = valid_q;

endmodule

[hdl/gdr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdr_ctrl: transaction controller of the duplicate replacer
// Takes one gene, launches the compare wave, picks the emitted value,
// drives the output register and the store and clear commands of the cells.
// ----------------------------------------------------------------------------
module gdr_ctrl #(
	parameter int MAX_GENES = gdr_pkg::DEF_MAX_GENES,
	parameter int GENE_BITS = gdr_pkg::DEF_GENE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [GENE_BITS-1:0] in_gene,
	input  logic [GENE_BITS-1:0] in_rep,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [GENE_BITS-1:0] out_gene,
	output logic                 out_replaced,
	output logic                 out_last,
	output logic                 out_overflow,
	output gdr_pkg::gdr_cmd_t    cmd,
	input  gdr_pkg::gdr_stat_t   stat,
	output logic [GENE_BITS-1:0] probe,
	output logic [GENE_BITS-1:0] emit
);
	import gdr_pkg::*;

	localparam int CNT_W = $clog2(MAX_GENES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_GENES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic                 start_q;
	logic                 dup_q;
	logic [GENE_BITS-1:0] gene_q;
	logic [GENE_BITS-1:0] rep_q;
	logic                 last_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	logic [GENE_BITS-1:0] out_gene_q;
	logic                 out_replaced_q;
	logic                 out_last_q;
	logic                 out_overflow_q;
	logic                 fire;
	logic                 full;

	// Result can move into the output register.
	assign full = (count_q == CNT_FULL);
	assign fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign emit = dup_q ? rep_q : gene_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign probe     = gene_q;
	assign cmd.start = start_q;
	assign cmd.shift = fire && !full;
	assign cmd.clear = fire && last_q;

	// State, sequencing and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			start_q        <= 1'b0;
			dup_q          <= 1'b0;
			gene_q         <= '0;
			rep_q          <= '0;
			last_q         <= 1'b0;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
			out_gene_q     <= '0;
			out_replaced_q <= 1'b0;
			out_last_q     <= 1'b0;
			out_overflow_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			// A new result refills the register in the cycle it drains.
			if (out_valid_q && out_ready && !fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						gene_q  <= in_gene;
						rep_q   <= in_rep;
						last_q  <= in_last;
						start_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.done) begin
						dup_q   <= stat.dup;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (fire) begin
						out_valid_q    <= 1'b1;
						out_gene_q     <= emit;
						out_replaced_q <= dup_q;
						out_last_q     <= last_q;
						out_overflow_q <= full;
						if (last_q) begin
							count_q <= '0;
						end else if (!full) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_gene     = out_gene_q;
	assign out_replaced = out_replaced_q;
	assign out_last     = out_last_q;
	assign out_overflow = out_overflow_q;

	// Fill count never passes the store size.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_FULL)
		else $error("gdr_ctrl: fill count beyond store size");

	// The wave only comes back while a scan is running.
	assert property (@(posedge clk) disable iff (!arst_n) stat.done |-> state_q == ST_SCAN)
		else $error("gdr_ctrl: compare wave finished outside a scan");

	// An accepted transaction launches exactly one compare wave.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (start_q && state_q == ST_SCAN))
		else $error("gdr_ctrl: accepted gene did not start a scan");

	// A store within a genome grows the fill count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && !last_q) |=> count_q == $past(count_q) + 1'b1)
		else $error("gdr_ctrl: store did not advance the fill count");

	// A full store is never shifted.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.shift |-> !full)
		else $error("gdr_ctrl: store shifted while full");

endmodule

[tb/genome_duplicate_replacer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genome_duplicate_replacer_core_tb: self-checking bench for the replacer
// Streams genomes of genes through the core and checks every emitted gene.
// A short table covers signed zeros, NaN words, repeated and already present
// replacement words, and genome ends. Random genomes follow; most are short,
// a few run past the store so that the overflow flag is exercised. Results of
// typed-in rows are checked as typed, others against a behavioral seen-value set.
// ----------------------------------------------------------------------------
module genome_duplicate_replacer_core_tb;

	localparam int GENES = gdr_pkg::DEF_MAX_GENES;
	localparam int GBITS = gdr_pkg::DEF_GENE_BITS;
	localparam int S_W   = ((2 * GBITS + 7) / 8) * 8;
	localparam int M_W   = ((GBITS + 7) / 8) * 8;
	localparam int N_ITEMS = 1450;
	localparam int N_ROWS  = 16;

	// One emitted gene as the core should present it.
	typedef struct packed {
		logic [GBITS-1:0] gene_out;
		logic             replaced;
		logic             last_out;
		logic             overflow;
	} emit_t;

	// One row of directed stimulus; known is set where the result is typed in.
	typedef struct packed {
		logic [GBITS-1:0] gene;
		logic [GBITS-1:0] repl;
		logic             last;
		logic             known;
		emit_t            res;
	} gene_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [S_W-1:0] s_tdata;
	logic           s_tlast;
	logic           m_tvalid;
	logic           m_tready;
	logic [M_W-1:0] m_tdata;
	logic [1:0]     m_tuser;
	logic           m_tlast;

	// Behavioral copy of the seen-value set of the current genome.
	logic [GBITS-1:0] seen_vals [GENES];
	bit               seen_ok   [GENES];
	int               fill_cnt;

	emit_t     emitted_q[$];
	gene_row_t dir_rows[N_ROWS];
	int        n_fail;
	int        n_sent;
	int        send_idle;
	int        recv_idle;

	genome_duplicate_replacer_core #(
		.MAX_GENES(GENES),
		.GENE_BITS(GBITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Replace a gene already emitted in this genome and record what goes out.
	function automatic emit_t replace_duplicate(logic [GBITS-1:0] gene,
			logic [GBITS-1:0] repl, logic last);
		emit_t r;
		bit    dup;
		dup = 1'b0;
		for (int p = 0; p < GENES; p++) begin
			if (seen_ok[p] && seen_vals[p] == gene)
				dup = 1'b1;
		end
		r.gene_out = dup ? repl : gene;
		r.replaced = dup;
		r.last_out = last;
		r.overflow = (fill_cnt >= GENES);
		if (!r.overflow) begin
			seen_vals[fill_cnt] = r.gene_out;
			seen_ok[fill_cnt]   = 1'b1;
			fill_cnt++;
		end
		// The set is dropped once the last gene of the genome is through.
		if (last) begin
			for (int p = 0; p < GENES; p++)
				seen_ok[p] = 1'b0;
			fill_cnt = 0;
		end
		return r;
	endfunction

	// Present one gene transaction and record its expected result on acceptance.
	task automatic send_gene(logic [GBITS-1:0] gene, logic [GBITS-1:0] repl,
			logic last, logic known, emit_t typed);
		emit_t r;
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {repl, gene};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = replace_duplicate(gene, repl, last);
		emitted_q.push_back(known ? typed : r);
		n_sent++;
		// Idle rates step through three phases over the run.
		if (n_sent == N_ITEMS / 3) begin
			send_idle = 59;
			recv_idle = 26;
		end else if (n_sent == 2 * N_ITEMS / 3) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	// Pick a gene: often one already in the set, sometimes a special word.
	function automatic logic [GBITS-1:0] pick_word(int pct_seen);
		int k;
		k = $urandom_range(99);
		if (k < pct_seen && fill_cnt > 0)
			return seen_vals[$urandom_range(fill_cnt - 1)];
		if (k < pct_seen + 15) begin
			case ($urandom_range(3))
				0: return '0;
				1: return {1'b1, {(GBITS-1){1'b0}}};
				2: return 32'h7FC0_0000;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	// Receiver: stall at random according to the current phase.
	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	// Check every accepted result against the oldest expectation.
	always @(posedge clk) begin
		emit_t e;
		if (m_tvalid && m_tready) begin
			if (emitted_q.size() == 0) begin
				$error("unexpected result: gene_out %h", m_tdata[GBITS-1:0]);
				n_fail++;
			end else begin
				e = emitted_q.pop_front();
				if (m_tdata[GBITS-1:0] !== e.gene_out) begin
					$error("gene_out: expected %h, got %h", e.gene_out, m_tdata[GBITS-1:0]);
					n_fail++;
				end
				if (m_tuser[0] !== e.replaced) begin
					$error("replaced: expected %b, got %b", e.replaced, m_tuser[0]);
					n_fail++;
				end
				if (m_tlast !== e.last_out) begin
					$error("last_out: expected %b, got %b", e.last_out, m_tlast);
					n_fail++;
				end
				if (m_tuser[1] !== e.overflow) begin
					$error("overflow: expected %b, got %b", e.overflow, m_tuser[1]);
					n_fail++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int            glen;
		logic [GBITS-1:0] g;
		logic [GBITS-1:0] rp;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		n_fail    = 0;
		n_sent    = 0;
		send_idle = 26;
		recv_idle = 59;
		fill_cnt  = 0;
		for (int p = 0; p < GENES; p++)
			seen_ok[p] = 1'b0;

		// gene, replacement, last, known, {gene_out, replaced, last_out, overflow}
		dir_rows[0]  = '{32'h0000_0000, 32'h0000_0001, 1'b0, 1'b1,
		                 '{32'h0000_0000, 1'b0, 1'b0, 1'b0}};
		// Negative zero differs from positive zero.
		dir_rows[1]  = '{32'h8000_0000, 32'h0000_0005, 1'b0, 1'b1,
		                 '{32'h8000_0000, 1'b0, 1'b0, 1'b0}};
		dir_rows[2]  = '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1,
		                 '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0}};
		// A NaN word matches itself; the replacement is already in the set.
		dir_rows[3]  = '{32'h7FC0_0000, 32'h0000_0003, 1'b0, 1'b1,
		                 '{32'h7FC0_0000, 1'b0, 1'b0, 1'b0}};
		dir_rows[4]  = '{32'h7FC0_0000, 32'h8000_0000, 1'b0, 1'b1,
		                 '{32'h8000_0000, 1'b1, 1'b0, 1'b0}};
		dir_rows[5]  = '{32'h8000_0000, 32'h1234_5678, 1'b0, 1'b1,
		                 '{32'h1234_5678, 1'b1, 1'b0, 1'b0}};
		dir_rows[6]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
		                 '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}};
		// A one-gene genome, then the set must be empty again.
		dir_rows[7]  = '{32'h0000_0000, 32'h0000_0009, 1'b1, 1'b1,
		                 '{32'h0000_0000, 1'b0, 1'b1, 1'b0}};
		dir_rows[8]  = '{32'h0000_0000, 32'h0000_0009, 1'b0, 1'b1,
		                 '{32'h0000_0000, 1'b0, 1'b0, 1'b0}};
		dir_rows[9]  = '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
		                 '{32'h0000_0000, 1'b1, 1'b0, 1'b0}};
		dir_rows[10] = '{32'h0000_0000, 32'hAAAA_AAAA, 1'b0, 1'b1,
		                 '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0}};
		dir_rows[11] = '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1,
		                 '{32'h5555_5555, 1'b1, 1'b0, 1'b0}};
		dir_rows[12] = '{32'h5555_5555, 32'h5555_5555, 1'b1, 1'b1,
		                 '{32'h5555_5555, 1'b1, 1'b1, 1'b0}};
		dir_rows[13] = '{32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b0, 1'b0, '0};
		dir_rows[14] = '{32'hDEAD_BEEF, 32'h0000_0001, 1'b0, 1'b0, '0};
		dir_rows[15] = '{32'h0000_0001, 32'hDEAD_BEEF, 1'b1, 1'b0, '0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_gene(dir_rows[i].gene, dir_rows[i].repl, dir_rows[i].last,
			          dir_rows[i].known, dir_rows[i].res);

		// Random genomes: the first one and a few more run past the store.
		for (int n = 0; n < 10000 && n_sent < N_ITEMS; n++) begin
			if (n == 0)
				glen = GENES + 3;
			else if ($urandom_range(99) < 4)
				glen = $urandom_range(GENES + 8, GENES - 2);
			else
				glen = $urandom_range(12, 1);
			for (int j = 0; j < glen; j++) begin
				g  = pick_word(40);
				rp = pick_word(25);
				send_gene(g, rp, (j == glen - 1), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (emitted_q.size() != 0)
			@(posedge clk);
		repeat (2 * GENES + 10) @(posedge clk);
		if (emitted_q.size() != 0)
			n_fail++;
		if (n_fail == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
